@@ rtl/core/fct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg
// Shared constants, codes and helpers for the frustum cull test core.
// ----------------------------------------------------------------------------
package fct_pkg;

    // number of clipping planes held in the plane store
    localparam int NUM_PLANES  = 6;
    // coordinates are taken as their low COORD_WIDTH bits, sign-extended
    localparam int COORD_WIDTH = 32;

    localparam int VAL_W   = 32;                 // coefficient and coordinate width
    localparam int PROD_W  = 2 * VAL_W;          // exact product width
    localparam int ACC_W   = PROD_W + 2;         // three products plus d and radius
    localparam int FRAC_W  = 16;                 // Q16.16 fraction bits
    localparam int RAD_W   = 31;
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int NUM_COEF = 4;
    localparam int NUM_AXES = 3;

    // request types
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_POINT  = 2'd1;
    localparam logic [1:0] REQ_SPHERE = 2'd2;
    localparam logic [1:0] REQ_BOX    = 2'd3;

    // coefficient select codes
    localparam logic [1:0] COEF_A = 2'd0;
    localparam logic [1:0] COEF_B = 2'd1;
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_D = 2'd3;

    // last axis index of the multiply sequence (z)
    localparam logic [1:0] AXIS_LAST = COEF_C;

    // take the low COORD_WIDTH bits of a coordinate and sign-extend them
    function automatic logic [VAL_W-1:0] coord_sext(input logic [VAL_W-1:0] raw);
        logic [VAL_W-1:0] r;
        r = raw;
        for (int i = COORD_WIDTH; i < VAL_W; i++) begin
            r[i] = raw[COORD_WIDTH-1];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/frustum_cull_test_core.sv @@
// a coefficient write gives no result; the core stays idle
// each plane is evaluated in turn: load d, multiply and accumulate per axis, check
// (one 32x32 multiplier, one multiply and one accumulate per axis, box takes two)
// evaluation stops at the first plane that culls
// one test in flight; the next word is taken while the result word waits
// reset (synchronous, active low) clears all plane coefficients to zero
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_test_core
// Plane store plus a sequenced multiply-accumulate unit that tests points,
// spheres and axis-aligned boxes against the loaded clipping planes.
// ----------------------------------------------------------------------------
module frustum_cull_test_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [2:0]  s_plane_sel,
    input  wire logic [1:0]  s_coef_sel,
    input  wire logic signed [31:0] s_coef_value,
    input  wire logic signed [31:0] s_pos_x,
    input  wire logic signed [31:0] s_pos_y,
    input  wire logic signed [31:0] s_pos_z,
    input  wire logic [30:0] s_sphere_radius,
    input  wire logic signed [31:0] s_hi_x,
    input  wire logic signed [31:0] s_hi_y,
    input  wire logic signed [31:0] s_hi_z,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_inside_res,
    output logic [1:0]       m_test_kind
);

    localparam int VAL_W  = fct_pkg::VAL_W;
    localparam int PROD_W = fct_pkg::PROD_W;
    localparam int ACC_W  = fct_pkg::ACC_W;
    localparam int PW     = fct_pkg::PLANE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [VAL_W-1:0] plane_store [fct_pkg::NUM_PLANES][fct_pkg::NUM_COEF];

    logic [2:0]        state_reg, state_next;
    logic [PW-1:0]     plane_reg, plane_next;
    logic [1:0]        axis_reg, axis_next;
    logic              side_reg, side_next;
    logic              inside_reg, inside_next;
    logic [1:0]        kind_reg;
    logic [VAL_W-1:0]  lo_reg [fct_pkg::NUM_AXES];
    logic [VAL_W-1:0]  hi_reg [fct_pkg::NUM_AXES];
    logic [fct_pkg::RAD_W-1:0] radius_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] lo_prod_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_inside_res_reg;
    logic [1:0]        m_test_kind_reg;

    logic              s_take;
    logic              out_load;
    logic signed [VAL_W-1:0]  coef_op;
    logic signed [VAL_W-1:0]  coord_op;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [PROD_W-1:0] term;
    logic [VAL_W-1:0]  d_coef;
    logic [ACC_W-1:0]  acc_init;
    logic [ACC_W-1:0]  bias;
    logic              nonpos;

    assign s_ready = (state_reg == S_IDLE);
    assign s_take  = s_valid && s_ready;

    // plane store, cleared at reset, one coefficient per write word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
                for (int c = 0; c < fct_pkg::NUM_COEF; c++) begin
                    plane_store[p][c] <= '0;
                end
            end
        end else if (s_take && s_req_type == fct_pkg::REQ_WRITE) begin
            for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
                if (32'(s_plane_sel) == p) begin
                    plane_store[p][s_coef_sel] <= s_coef_value;
                end
            end
        end
    end

    // operand capture for a test word
    always_ff @(posedge aclk) begin
        if (s_take) begin
            kind_reg   <= s_req_type;
            lo_reg[0]  <= fct_pkg::coord_sext(s_pos_x);
            lo_reg[1]  <= fct_pkg::coord_sext(s_pos_y);
            lo_reg[2]  <= fct_pkg::coord_sext(s_pos_z);
            hi_reg[0]  <= fct_pkg::coord_sext(s_hi_x);
            hi_reg[1]  <= fct_pkg::coord_sext(s_hi_y);
            hi_reg[2]  <= fct_pkg::coord_sext(s_hi_z);
            radius_reg <= s_sphere_radius;
        end
    end

    // shared multiplier
    assign coef_op  = plane_store[plane_reg][axis_reg];
    assign coord_op = side_reg ? hi_reg[axis_reg] : lo_reg[axis_reg];
    assign mul_out  = coef_op * coord_op;

    // box: the corner that maximizes the sum takes the larger product per axis
    assign term = (kind_reg == fct_pkg::REQ_BOX && prod_reg < lo_prod_reg) ?
                  lo_prod_reg : prod_reg;

    assign d_coef   = plane_store[plane_reg][fct_pkg::COEF_D];
    assign bias     = (kind_reg == fct_pkg::REQ_SPHERE) ?
                      {{(ACC_W - fct_pkg::RAD_W - fct_pkg::FRAC_W){1'b0}}, radius_reg,
                       {fct_pkg::FRAC_W{1'b0}}} : '0;
    assign acc_init = ({{(ACC_W - VAL_W){d_coef[VAL_W-1]}}, d_coef} << fct_pkg::FRAC_W)
                      + bias;
    assign nonpos   = acc_reg[ACC_W-1] || (acc_reg == '0);

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        plane_next  = plane_reg;
        axis_next   = axis_reg;
        side_next   = side_reg;
        inside_next = inside_reg;
        acc_next    = acc_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_take && s_req_type != fct_pkg::REQ_WRITE) begin
                    state_next  = S_INIT;
                    plane_next  = '0;
                    inside_next = 1'b1;
                end
            end
            S_INIT: begin
                acc_next   = acc_init;
                axis_next  = fct_pkg::COEF_A;
                side_next  = 1'b0;
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                if (kind_reg == fct_pkg::REQ_BOX && !side_reg) begin
                    side_next  = 1'b1;
                    state_next = S_MUL;
                end else begin
                    acc_next  = acc_reg + {{(ACC_W - PROD_W){term[PROD_W-1]}}, term};
                    side_next = 1'b0;
                    if (axis_reg == fct_pkg::AXIS_LAST) begin
                        state_next = S_CHK;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_CHK: begin
                if (nonpos) begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end else if (32'(plane_reg) == fct_pkg::NUM_PLANES - 1) begin
                    state_next = S_DONE;
                end else begin
                    plane_next = plane_reg + PW'(1);
                    state_next = S_INIT;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            plane_reg   <= '0;
            axis_reg    <= fct_pkg::COEF_A;
            side_reg    <= 1'b0;
            inside_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            plane_reg   <= plane_next;
            axis_reg    <= axis_next;
            side_reg    <= side_next;
            inside_reg  <= inside_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (state_reg == S_MUL) begin
            prod_reg <= mul_out;
        end
        if (state_reg == S_ADD && !side_reg) begin
            lo_prod_reg <= prod_reg;
        end
        if (out_load) begin
            m_inside_res_reg <= inside_reg;
            m_test_kind_reg  <= kind_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_res_reg;
    assign m_test_kind  = m_test_kind_reg;

    // a test word always starts at the first plane
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && s_req_type != fct_pkg::REQ_WRITE) |=>
        (state_reg == S_INIT && plane_reg == '0))
        else $error("test did not start at plane zero");

    // only the three coordinate axes are ever multiplied
    a_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (axis_reg != fct_pkg::COEF_D))
        else $error("axis index out of range");

    // the max-corner operand is used by box tests only
    a_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL && kind_reg != fct_pkg::REQ_BOX) |-> !side_reg)
        else $error("high corner used outside a box test");

    // plane counter stays within the store while evaluating
    a_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (32'(plane_reg) < fct_pkg::NUM_PLANES))
        else $error("plane index out of range");

    // a result word always echoes a test, never a write
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_test_kind_reg != fct_pkg::REQ_WRITE))
        else $error("result word carries a write type");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// frustum cull test core bench
// Loads clipping planes one coefficient at a time and sends point, sphere and
// box tests while both handshake sides idle at random. Every verdict is
// compared with an exact wide-sum model of the plane tests kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PLANES    = fct_pkg::NUM_PLANES;
    localparam int NUM_COEF      = fct_pkg::NUM_COEF;
    localparam int FRAC_W        = fct_pkg::FRAC_W;
    localparam int COORD_WIDTH   = fct_pkg::COORD_WIDTH;

    localparam int CLK_HALF      = 5;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int SUM_W         = 72;
    localparam int ONE           = 65536;

    typedef struct {
        logic [1:0]  req_type;
        logic [2:0]  plane_sel;
        logic [1:0]  coef_sel;
        logic [31:0] coef_value;
        logic [31:0] pos_x, pos_y, pos_z;
        logic [30:0] radius;
        logic [31:0] hi_x, hi_y, hi_z;
    } cull_word_t;

    typedef struct {
        logic       in_view;
        logic [1:0] kind;
    } verdict_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type      = '0;
    logic [2:0]  s_plane_sel     = '0;
    logic [1:0]  s_coef_sel      = '0;
    logic [31:0] s_coef_value    = '0;
    logic [31:0] s_pos_x         = '0;
    logic [31:0] s_pos_y         = '0;
    logic [31:0] s_pos_z         = '0;
    logic [30:0] s_sphere_radius = '0;
    logic [31:0] s_hi_x          = '0;
    logic [31:0] s_hi_y          = '0;
    logic [31:0] s_hi_z          = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_inside_res;
    logic [1:0]  m_test_kind;

    // bench copy of the plane store, cleared like the block at reset
    logic [31:0] plane_coef [NUM_PLANES*NUM_COEF] = '{default: '0};
    verdict_t    verdict_q [$];
    verdict_t    want;

    int       fr_lo [3];
    int       fr_hi [3];
    bit       gaps_on     = 1'b1;
    int       burst_left  = 0;
    int       hold_req    = 0;
    int       hold_seen   = 0;
    int       hold_left   = 0;
    rx_mode_t rx_mode     = RX_OPEN;
    int       rx_cycle    = 0;
    int       cycle_count = 0;
    int       err_count   = 0;
    int       n_writes    = 0;
    int       n_ignored   = 0;
    int       n_tests [4] = '{default: 0};
    int       n_results   = 0;
    int       n_inside    = 0;

    frustum_cull_test_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_plane_sel     (s_plane_sel),
        .s_coef_sel      (s_coef_sel),
        .s_coef_value    (s_coef_value),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_sphere_radius (s_sphere_radius),
        .s_hi_x          (s_hi_x),
        .s_hi_y          (s_hi_y),
        .s_hi_z          (s_hi_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inside_res    (m_inside_res),
        .m_test_kind     (m_test_kind)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic logic signed [SUM_W-1:0] coord_q(input logic [31:0] raw);
        return SUM_W'($signed(raw[COORD_WIDTH-1:0]));
    endfunction

    // a*x + b*y + c*z + d + bias <= 0 on plane p, all terms in Q32.32
    function automatic logic plane_nonpos(input int p,
                                          input logic signed [SUM_W-1:0] x, y, z, bias);
        logic signed [SUM_W-1:0] ca, cb, cc, cd, plane_sum;
        ca = SUM_W'($signed(plane_coef[p*NUM_COEF + fct_pkg::COEF_A]));
        cb = SUM_W'($signed(plane_coef[p*NUM_COEF + fct_pkg::COEF_B]));
        cc = SUM_W'($signed(plane_coef[p*NUM_COEF + fct_pkg::COEF_C]));
        cd = SUM_W'($signed(plane_coef[p*NUM_COEF + fct_pkg::COEF_D]));
        plane_sum = ca * x + cb * y + cc * z + (cd <<< FRAC_W) + bias;
        return plane_sum <= 0;
    endfunction

    function automatic verdict_t cull_verdict(input cull_word_t w);
        logic signed [SUM_W-1:0] lo [3];
        logic signed [SUM_W-1:0] hi [3];
        logic signed [SUM_W-1:0] bias;
        logic                    all_out;
        verdict_t                v;
        lo[0] = coord_q(w.pos_x);
        lo[1] = coord_q(w.pos_y);
        lo[2] = coord_q(w.pos_z);
        hi[0] = coord_q(w.hi_x);
        hi[1] = coord_q(w.hi_y);
        hi[2] = coord_q(w.hi_z);
        bias = {{(SUM_W-31){1'b0}}, w.radius};
        bias = bias <<< FRAC_W;
        v.kind = w.req_type;
        v.in_view = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (w.req_type == fct_pkg::REQ_BOX) begin
                // culled only when every corner is on the outer side
                all_out = 1'b1;
                for (int k = 0; k < 8; k++) begin
                    if (!plane_nonpos(p, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                      k[2] ? hi[2] : lo[2], '0)) begin
                        all_out = 1'b0;
                    end
                end
                if (all_out) begin
                    v.in_view = 1'b0;
                end
            end else if (w.req_type == fct_pkg::REQ_SPHERE) begin
                if (plane_nonpos(p, lo[0], lo[1], lo[2], bias)) begin
                    v.in_view = 1'b0;
                end
            end else if (plane_nonpos(p, lo[0], lo[1], lo[2], '0)) begin
                v.in_view = 1'b0;
            end
        end
        return v;
    endfunction

    // every field random, the caller overrides what matters
    function automatic cull_word_t noise_word();
        cull_word_t w;
        w.req_type   = 2'($urandom_range(fct_pkg::REQ_WRITE, fct_pkg::REQ_BOX));
        w.plane_sel  = 3'($urandom_range(0, 7));
        w.coef_sel   = 2'($urandom_range(fct_pkg::COEF_A, fct_pkg::COEF_D));
        w.coef_value = $urandom;
        w.pos_x      = $urandom;
        w.pos_y      = $urandom;
        w.pos_z      = $urandom;
        w.radius     = 31'($urandom);
        w.hi_x       = $urandom;
        w.hi_y       = $urandom;
        w.hi_z       = $urandom;
        return w;
    endfunction

    function automatic cull_word_t coef_word(input int plane, input logic [1:0] coef,
                                             input logic [31:0] value);
        cull_word_t w;
        w = noise_word();
        w.req_type   = fct_pkg::REQ_WRITE;
        w.plane_sel  = 3'(plane);
        w.coef_sel   = coef;
        w.coef_value = value;
        return w;
    endfunction

    function automatic cull_word_t shape_word(input logic [1:0] kind,
                                              input logic [31:0] lx, ly, lz,
                                              input logic [31:0] rad,
                                              input logic [31:0] ux, uy, uz);
        cull_word_t w;
        w = noise_word();
        w.req_type = kind;
        w.pos_x    = lx;
        w.pos_y    = ly;
        w.pos_z    = lz;
        w.radius   = rad[30:0];
        w.hi_x     = ux;
        w.hi_y     = uy;
        w.hi_z     = uz;
        return w;
    endfunction

    // test near the current box-shaped frustum, some on a face or corner-swapped
    function automatic cull_word_t frustum_shape();
        cull_word_t w;
        int         lo_c [3];
        int         hi_c [3];
        int         span, tmp, ax;
        logic [1:0] kind;
        logic [31:0] rad;
        kind = 2'($urandom_range(fct_pkg::REQ_POINT, fct_pkg::REQ_BOX));
        for (int a = 0; a < 3; a++) begin
            span = fr_hi[a] - fr_lo[a];
            lo_c[a] = fr_lo[a] - span / 2 + int'($urandom_range(0, 2 * span));
            if ($urandom_range(0, 7) == 0) begin
                lo_c[a] = $urandom_range(0, 1) ? fr_lo[a] : fr_hi[a];
            end
            hi_c[a] = lo_c[a] + int'($urandom_range(0, span));
        end
        if (kind == fct_pkg::REQ_BOX && $urandom_range(0, 7) == 0) begin
            ax = $urandom_range(0, 2);
            tmp = lo_c[ax];
            lo_c[ax] = hi_c[ax];
            hi_c[ax] = tmp;
        end
        case ($urandom_range(0, 9))
            0: rad = '0;
            1: rad = $urandom;
            default: rad = $urandom_range(0, fr_hi[0] - fr_lo[0]);
        endcase
        w = shape_word(kind, lo_c[0], lo_c[1], lo_c[2], rad, hi_c[0], hi_c[1], hi_c[2]);
        if ($urandom_range(0, 19) == 0) begin
            w.pos_x = $urandom;
            w.pos_z = $urandom;
        end
        return w;
    endfunction

    // offer one word, hold it until taken, then update the bench plane store or queue the verdict
    task automatic push_word(input cull_word_t w);
        int gap;
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_valid         <= 1'b1;
        s_req_type      <= w.req_type;
        s_plane_sel     <= w.plane_sel;
        s_coef_sel      <= w.coef_sel;
        s_coef_value    <= w.coef_value;
        s_pos_x         <= w.pos_x;
        s_pos_y         <= w.pos_y;
        s_pos_z         <= w.pos_z;
        s_sphere_radius <= w.radius;
        s_hi_x          <= w.hi_x;
        s_hi_y          <= w.hi_y;
        s_hi_z          <= w.hi_z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.req_type == fct_pkg::REQ_WRITE) begin
            n_writes++;
            if (w.plane_sel < NUM_PLANES) begin
                plane_coef[w.plane_sel*NUM_COEF + w.coef_sel] = w.coef_value;
            end else begin
                n_ignored++;
            end
        end else begin
            n_tests[w.req_type]++;
            verdict_q.push_back(cull_verdict(w));
        end
    endtask

    task automatic load_plane(input int p, input int a, b, c, d);
        push_word(coef_word(p, fct_pkg::COEF_A, a));
        push_word(coef_word(p, fct_pkg::COEF_B, b));
        push_word(coef_word(p, fct_pkg::COEF_C, c));
        push_word(coef_word(p, fct_pkg::COEF_D, d));
    endtask

    // six planes bounding an axis-aligned region, optionally a little tilted
    task automatic load_frustum(input bit tilt);
        int ctr, ext;
        int cv [3];
        for (int a = 0; a < 3; a++) begin
            ctr = $urandom_range(0, 100 * ONE) - 50 * ONE;
            ext = $urandom_range(ONE / 4, 40 * ONE);
            fr_lo[a] = ctr - ext;
            fr_hi[a] = ctr + ext;
        end
        for (int a = 0; a < 3; a++) begin
            for (int side = 0; side < 2; side++) begin
                for (int j = 0; j < 3; j++) begin
                    cv[j] = tilt ? int'($urandom_range(0, ONE / 8)) - ONE / 16 : 0;
                end
                cv[a] = side ? -ONE : ONE;
                load_plane(2 * a + side, cv[0], cv[1], cv[2], side ? fr_hi[a] : -fr_lo[a]);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // nothing loaded yet: every plane coefficient is zero
    task automatic test_cleared_planes();
        push_word(shape_word(fct_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_SPHERE, 32'h8000_0000, 32'h7fff_ffff, 0, 1,
                             0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_BOX, -ONE, -ONE, -ONE, 0, ONE, ONE, ONE));
    endtask

    task automatic test_ignored_writes();
        push_word(coef_word(6, fct_pkg::COEF_A, 32'h7fff_ffff));
        push_word(coef_word(7, fct_pkg::COEF_D, 32'h7fff_ffff));
        push_word(shape_word(fct_pkg::REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_extreme_values();
        load_plane(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_word(shape_word(fct_pkg::REQ_SPHERE, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_SPHERE, 32'h7fff_ffff, 32'h8000_0000,
                             32'h7fff_ffff, 1, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_POINT, 32'h8000_0000, 32'h7fff_ffff,
                             32'h8000_0000, 0, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    endtask

    // sphere touching the plane from outside: sum equals minus the radius
    task automatic test_exact_boundary();
        load_plane(0, ONE, 0, 0, 0);
        push_word(shape_word(fct_pkg::REQ_SPHERE, -5 * ONE, ONE, 0, 5 * ONE, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_SPHERE, -5 * ONE + 1, ONE, 0, 5 * ONE, 0, 0, 0));
        push_word(shape_word(fct_pkg::REQ_SPHERE, ONE, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_frustums(input int rounds, input int per_round);
        for (int r = 0; r < rounds; r++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            load_frustum($urandom_range(0, 1));
            for (int t = 0; t < per_round; t++) begin
                if ($urandom_range(0, 15) == 0) begin
                    push_word(coef_word($urandom_range(NUM_PLANES, 7),
                                        2'($urandom_range(fct_pkg::COEF_A, fct_pkg::COEF_D)),
                                        $urandom));
                end
                push_word(frustum_shape());
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_planes(input int count);
        cull_word_t w;
        for (int p = 0; p < NUM_PLANES; p++) begin
            load_plane(p, $urandom, $urandom, $urandom, $urandom);
        end
        for (int t = 0; t < count; t++) begin
            w = noise_word();
            w.req_type = 2'($urandom_range(fct_pkg::REQ_POINT, fct_pkg::REQ_BOX));
            push_word(w);
        end
    endtask

    // sink holds off for a long stretch while words keep coming
    task automatic test_output_stall();
        hold_req <= hold_req + 1;
        gaps_on = 1'b0;
        for (int t = 0; t < 16; t++) begin
            push_word(frustum_shape());
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        wait_drained();
        gaps_on = 1'b0;
        for (int t = 0; t < 10; t++) begin
            push_word(frustum_shape());
        end
        gaps_on = 1'b1;
    endtask

    // result sink: a stall pattern picked at random from four modes, with a long hold on request
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (rx_cycle % 5) < 3;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result word with nothing expected, inside_res %0b test_kind %0d",
                         $time, m_inside_res, m_test_kind);
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                n_results++;
                if (want.in_view) begin
                    n_inside++;
                end
                if (m_inside_res !== want.in_view) begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.in_view, m_inside_res);
                    err_count++;
                end
                if (m_test_kind !== want.kind) begin
                    $display("%0t: test_kind expected %0d actual %0d",
                             $time, want.kind, m_test_kind);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_cleared_planes();
        test_ignored_writes();
        test_extreme_values();
        test_exact_boundary();
        test_random_frustums(3, 25);
        test_output_stall();
        test_random_planes(20);
        test_random_frustums(3, 25);
        test_drain_pause();

        wait_drained();
        $display("sent %0d plane writes (%0d absent), %0d point, %0d sphere, %0d box tests",
                 n_writes, n_ignored, n_tests[fct_pkg::REQ_POINT],
                 n_tests[fct_pkg::REQ_SPHERE], n_tests[fct_pkg::REQ_BOX]);
        $display("checked %0d verdicts: %0d inside, %0d culled, %0d errors",
                 n_results, n_inside, n_results - n_inside, err_count);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/fct_pkg.sv
rtl/core/frustum_cull_test_core.sv
test/testbench.sv
